// ===== sv/ansi_sgr_color_filter_unit_assert.svh =====
// assertion macros for the sgr color filter
`ifndef ANSI_SGR_COLOR_FILTER_UNIT_ASSERT_SVH
`define ANSI_SGR_COLOR_FILTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SGRCF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SGRCF_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SGRCF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SGRCF_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== sv/sgrcf_pkg.sv =====
// shared types, constants and helpers for the sgr color filter
package sgrcf_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'd27;
  localparam logic [7:0] OPEN_BYTE = 8'h5B;
  localparam logic [7:0] END_BYTE  = 8'h6D;
  localparam logic [7:0] SEP_BYTE  = 8'h3B;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [7:0] FG_LOW    = 8'd30;
  localparam logic [7:0] FG_HIGH   = 8'd37;
  localparam logic [7:0] BG_LOW    = 8'd40;
  localparam logic [7:0] BG_HIGH   = 8'd47;

  localparam logic [2:0] FG_RESET = 3'd7;
  localparam logic [2:0] BG_RESET = 3'd0;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;
  localparam logic OUT_CHAR  = 1'b0;
  localparam logic OUT_ATTR  = 1'b1;

  localparam logic REG_DEFAULT_FG = 1'b0;
  localparam logic REG_DEFAULT_BG = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_char;
    logic [7:0] attribute;
    logic       last;
  } out_item_t;

  // one request's worth of results, handed from front to back
  typedef struct packed {
    logic       esc_first;
    logic       has_main;
    logic       main_kind;
    logic [7:0] main_val;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] swap_rb(input logic [2:0] c);
    swap_rb = {c[0], c[1], c[2]};
  endfunction

endpackage

// ===== sv/sgrcf_front.sv =====
// front end: accepts bytes, runs the escape parser, queues result ops
module sgrcf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  sgrcf_pkg::in_item_t  in_data,
  input  logic                 accept,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [2:0]           cfg_data,
  output logic                 push,
  output sgrcf_pkg::op_t       push_op
);

  sgrcf_pkg::mode_t mode, mode_next;
  logic [7:0] param, param_next;
  logic       closed, closed_next;
  logic [2:0] pending_fg, pending_fg_next;
  logic [2:0] pending_bg, pending_bg_next;
  logic [2:0] default_fg, default_bg;

  logic [7:0]  b;
  logic        is_digit;
  logic [11:0] prod;
  logic [11:0] acc;
  logic [2:0]  fg_app, bg_app;
  logic [7:0]  fg_off, bg_off;
  sgrcf_pkg::op_t op;

  assign b        = in_data.in_byte;
  assign is_digit = (b >= sgrcf_pkg::DIGIT_LO) && (b <= sgrcf_pkg::DIGIT_HI);
  assign prod     = {4'b0, param} * 12'd10;
  assign acc      = prod + {8'b0, b[3:0]};
  assign fg_off   = param - sgrcf_pkg::FG_LOW;
  assign bg_off   = param - sgrcf_pkg::BG_LOW;
  assign fg_app   = (param >= sgrcf_pkg::FG_LOW && param <= sgrcf_pkg::FG_HIGH) ?
                    sgrcf_pkg::swap_rb(fg_off[2:0]) : pending_fg;
  assign bg_app   = (param >= sgrcf_pkg::BG_LOW && param <= sgrcf_pkg::BG_HIGH) ?
                    sgrcf_pkg::swap_rb(bg_off[2:0]) : pending_bg;

  always_comb begin
    mode_next = mode;
    if (in_data.kind == sgrcf_pkg::KIND_EOS) begin
      mode_next = sgrcf_pkg::MODE_TEXT;
    end else begin
      unique case (mode)
        sgrcf_pkg::MODE_SEQ: begin
          mode_next = (b == sgrcf_pkg::END_BYTE) ? sgrcf_pkg::MODE_TEXT : sgrcf_pkg::MODE_SEQ;
        end
        sgrcf_pkg::MODE_ESC: begin
          if (b == sgrcf_pkg::OPEN_BYTE) begin
            mode_next = sgrcf_pkg::MODE_SEQ;
          end else if (b == sgrcf_pkg::ESC_BYTE) begin
            mode_next = sgrcf_pkg::MODE_ESC;
          end else begin
            mode_next = sgrcf_pkg::MODE_TEXT;
          end
        end
        default: begin
          mode_next = (b == sgrcf_pkg::ESC_BYTE) ? sgrcf_pkg::MODE_ESC : sgrcf_pkg::MODE_TEXT;
        end
      endcase
    end
  end

  always_comb begin
    param_next      = param;
    closed_next     = closed;
    pending_fg_next = pending_fg;
    pending_bg_next = pending_bg;
    op              = '0;
    if (in_data.kind == sgrcf_pkg::KIND_EOS) begin
      op.esc_first = (mode == sgrcf_pkg::MODE_ESC);
      param_next   = '0;
      closed_next  = 1'b0;
    end else begin
      unique case (mode)
        sgrcf_pkg::MODE_SEQ: begin
          if (b == sgrcf_pkg::END_BYTE || b == sgrcf_pkg::SEP_BYTE) begin
            pending_fg_next = fg_app;
            pending_bg_next = bg_app;
            param_next      = '0;
            closed_next     = 1'b0;
            if (b == sgrcf_pkg::END_BYTE) begin
              op.has_main  = 1'b1;
              op.main_kind = sgrcf_pkg::OUT_ATTR;
              op.main_val  = {1'b0, bg_app, 1'b0, fg_app};
            end
          end else if (!closed && is_digit) begin
            param_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
          end else begin
            closed_next = 1'b1;
          end
        end
        sgrcf_pkg::MODE_ESC: begin
          if (b == sgrcf_pkg::OPEN_BYTE) begin
            param_next      = '0;
            closed_next     = 1'b0;
            pending_fg_next = default_fg;
            pending_bg_next = default_bg;
          end else begin
            op.esc_first = 1'b1;
            op.has_main  = (b != sgrcf_pkg::ESC_BYTE);
            op.main_kind = sgrcf_pkg::OUT_CHAR;
            op.main_val  = b;
          end
        end
        default: begin
          op.has_main  = (b != sgrcf_pkg::ESC_BYTE);
          op.main_kind = sgrcf_pkg::OUT_CHAR;
          op.main_val  = b;
        end
      endcase
    end
  end

  assign push    = accept && in_valid && (op.esc_first || op.has_main);
  assign push_op = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sgrcf_pkg::MODE_TEXT;
      param      <= '0;
      closed     <= 1'b0;
      pending_fg <= sgrcf_pkg::FG_RESET;
      pending_bg <= sgrcf_pkg::BG_RESET;
      default_fg <= sgrcf_pkg::FG_RESET;
      default_bg <= sgrcf_pkg::BG_RESET;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        param      <= param_next;
        closed     <= closed_next;
        pending_fg <= pending_fg_next;
        pending_bg <= pending_bg_next;
      end
      if (cfg_write) begin
        if (cfg_index == sgrcf_pkg::REG_DEFAULT_FG) begin
          default_fg <= cfg_data;
        end else begin
          default_bg <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== sv/sgrcf_queue.sv =====
// small fifo of result ops between front and back
module sgrcf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sgrcf_pkg::op_t        push_op,
  input  logic                  pop,
  output sgrcf_pkg::op_t        head,
  output sgrcf_pkg::q_status_t  status
);

  sgrcf_pkg::op_t mem [sgrcf_pkg::QDEPTH];
  logic [sgrcf_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [sgrcf_pkg::QAW:0]   count;

  assign head         = mem[rd_ptr];
  assign status.full  = (count == (sgrcf_pkg::QAW+1)'(sgrcf_pkg::QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/sgrcf_back.sv =====
// back end: expands queued ops into result items through an output register
module sgrcf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sgrcf_pkg::op_t        head,
  input  sgrcf_pkg::q_status_t  status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgrcf_pkg::out_item_t  out_data
);

  logic phase;
  logic load;
  logic esc_step;
  sgrcf_pkg::out_item_t item;

  assign load     = (!out_valid || !out_stall) && !status.empty;
  assign esc_step = head.esc_first && !phase;
  assign pop      = load && !(esc_step && head.has_main);

  always_comb begin
    item = '0;
    if (esc_step) begin
      item.out_kind = sgrcf_pkg::OUT_CHAR;
      item.out_char = sgrcf_pkg::ESC_BYTE;
      item.last     = !head.has_main;
    end else begin
      item.out_kind = head.main_kind;
      if (head.main_kind == sgrcf_pkg::OUT_ATTR) begin
        item.attribute = head.main_val;
      end else begin
        item.out_char = head.main_val;
      end
      item.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= esc_step && head.has_main;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/ansi_sgr_color_filter_unit.sv =====
// top level of the sgr color filter
// one byte request accepted per cycle while the op queue has room
// accepted bytes' ops are written into the op queue, then loaded into the output register
// a byte that gives two results sends the esc first, then its main result; out_stall holds the output
// synchronous reset returns to text mode, empties the queue, defaults 7 and 0
module ansi_sgr_color_filter_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sgrcf_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgrcf_pkg::out_item_t  out_data,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [2:0]            cfg_data
);

`include "ansi_sgr_color_filter_unit_assert.svh"

  logic                 accept;
  logic                 push;
  logic                 pop;
  sgrcf_pkg::op_t       push_op;
  sgrcf_pkg::op_t       head;
  sgrcf_pkg::q_status_t status;
  logic                 out_mid;
  logic                 out_esc_char;
  logic                 out_attr;
  logic                 attr_shape_ok;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  sgrcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .accept    (accept),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_op   (push_op)
  );

  sgrcf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  sgrcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_mid       = out_valid && !out_data.last;
  assign out_esc_char  = (out_data.out_kind == sgrcf_pkg::OUT_CHAR) &&
                         (out_data.out_char == sgrcf_pkg::ESC_BYTE);
  assign out_attr      = out_valid && (out_data.out_kind == sgrcf_pkg::OUT_ATTR);
  assign attr_shape_ok = (out_data.out_char == 8'd0) && (out_data.attribute[7] == 1'b0) &&
                         (out_data.attribute[3] == 1'b0);

  `SGRCF_ASSERT_NEVER(a_no_overflow, clk, rst, push && status.full, "push into full queue")
  `SGRCF_ASSERT_NEVER(a_no_underflow, clk, rst, pop && status.empty, "pop from empty queue")
  `SGRCF_ASSERT_IMPL(a_first_is_esc, clk, rst, out_mid, out_esc_char, "non-final result is not esc")
  `SGRCF_ASSERT_IMPL(a_attr_clean, clk, rst, out_attr, attr_shape_ok, "malformed attribute")

endmodule
